[hdl/fitg_pkg.sv]
// ----------------------------------------------------------------------------
// fitg_pkg
// Shared types and constants of the impulse-train generator: phase width,
// fixed-point scaling, register indexes, controller states and the command
// and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package fitg_pkg;

  localparam int PHASE_BITS = 32;
  localparam int CFG_W      = 32;
  localparam int GAIN_W     = 16;
  localparam int FM_W       = 16;
  localparam int MAG_W      = FM_W + 1;
  localparam int PROD_W     = 31;
  localparam int Q_SHIFT    = 27;
  localparam int DIV_W      = 32;
  localparam int DIV_STEPS  = PHASE_BITS;
  localparam int CNT_W      = $clog2(DIV_STEPS);
  localparam int OUT_W      = 15;
  localparam int REG_IDX_W  = 2;

  localparam logic [DIV_W-1:0]      ONE_Q          = DIV_W'(1) << Q_SHIFT;
  localparam logic [OUT_W-1:0]      IMPULSE_LEVEL  = OUT_W'(32440);
  localparam logic [CFG_W-1:0]      BASE_RESET     = CFG_W'(89478);
  localparam logic [GAIN_W-1:0]     GAIN_RESET     = '0;
  localparam logic                  ENABLE_RESET   = 1'b1;

  localparam logic [REG_IDX_W-1:0]  REG_BASE_INC   = 2'd0;
  localparam logic [REG_IDX_W-1:0]  REG_FM_GAIN    = 2'd1;
  localparam logic [REG_IDX_W-1:0]  REG_FM_ENABLE  = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MAG  = 5'b00010,
    S_MUL  = 5'b00100,
    S_DIV  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  typedef enum logic [1:0] {
    K_BYPASS = 2'd0,
    K_POS    = 2'd1,
    K_NEG    = 2'd2
  } kind_t;

  typedef struct packed {
    logic load;
    logic mag;
    logic mul;
    logic div_step;
    logic fin;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
  } status_t;

endpackage

[hdl/fm_impulse_train_generator_top.sv]
// ----------------------------------------------------------------------------
// fm_impulse_train_generator_top
// Impulse-train oscillator with a phase accumulator and bipolar FM of the
// phase increment.
//
//   channel   signals                         payload
//   input     in_valid / in_stall             fm_sample
//   output    out_valid / out_stall           sample_out, impulse
//   config    wr_en / wr_index / wr_data      base_increment, fm_gain, fm_enable
//
// an item with positive, zero or disabled FM steps through magnitude,
// multiply and finish; one with negative FM also passes the restoring
// divider between multiply and finish, at one quotient bit per cycle
// reset is synchronous: phase to zero, registers to their defaults
// a stalled output holds its item; the next item is taken meanwhile and
// waits in its finish step until the output register frees
// ----------------------------------------------------------------------------
module fm_impulse_train_generator_top
  import fitg_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  logic [REG_IDX_W-1:0]   wr_index,
  input  logic [CFG_W-1:0]       wr_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic signed [FM_W-1:0] fm_sample,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [OUT_W-1:0]       sample_out,
  output logic                   impulse
);

  cmd_t    cmd;
  status_t status;

  fitg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  fitg_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .fm_sample  (fm_sample),
    .cmd        (cmd),
    .status     (status),
    .sample_out (sample_out),
    .impulse    (impulse)
  );

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("accepted item did not make the block busy");

  assert property (@(posedge clk) disable iff (rst)
    cmd.fin |-> (!out_valid || !out_stall))
    else $error("result overwrote a pending output item");

  assert property (@(posedge clk) disable iff (rst)
    cmd.fin |=> out_valid)
    else $error("finished item not presented");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((impulse && sample_out == IMPULSE_LEVEL) ||
                   (!impulse && sample_out == '0)))
    else $error("sample level disagrees with impulse flag");
`endif

endmodule

[hdl/fitg_ctrl.sv]
// ----------------------------------------------------------------------------
// fitg_ctrl
// Controller of the impulse-train generator: steps one item through the
// magnitude, multiply, divide (negative FM only) and finish phases and owns the output valid.
// ----------------------------------------------------------------------------
module fitg_ctrl
  import fitg_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  status_t status,
  output cmd_t    cmd
);

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] count;
  logic             out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next   = state;
    cmd          = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MAG;
        end
      end
      S_MAG: begin
        cmd.mag    = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = (status.kind == K_NEG) ? S_DIV : S_FIN;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (count == CNT_W'(DIV_STEPS - 1)) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.fin    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DIV) begin
        count <= count + CNT_W'(1);
      end else begin
        count <= '0;
      end
      if (cmd.fin) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[hdl/fitg_datapath.sv]
// ----------------------------------------------------------------------------
// fitg_datapath
// Datapath of the impulse-train generator: configuration registers, FM
// magnitude and gain product, increment multiply, restoring divider, phase
// accumulator and output register.
// ----------------------------------------------------------------------------
module fitg_datapath
  import fitg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [REG_IDX_W-1:0]  wr_index,
  input  logic [CFG_W-1:0]      wr_data,
  input  logic signed [FM_W-1:0] fm_sample,
  input  cmd_t                  cmd,
  output status_t               status,
  output logic [OUT_W-1:0]      sample_out,
  output logic                  impulse
);

  localparam int PB = PHASE_BITS;

  logic [CFG_W-1:0]          base_increment;
  logic [GAIN_W-1:0]         fm_gain;
  logic                      fm_enable;
  logic [PB-1:0]             phase;

  logic [FM_W-1:0]           fm;
  logic [PROD_W-1:0]         prod;
  logic [PB+DIV_W-1:0]       product;
  logic [DIV_W-1:0]          divisor;
  logic [DIV_W-1:0]          rem;
  logic [PB-1:0]             quo;

  logic [PB+CFG_W-1:0]       base_wide;
  logic [PB-1:0]             base_sat;
  logic [MAG_W-1:0]          mag;
  logic [MAG_W+GAIN_W-1:0]   prod_full;
  logic [DIV_W-1:0]          factor;
  logic [PB+Q_SHIFT-1:0]     dividend;
  logic [DIV_W:0]            trial;
  logic [DIV_W:0]            diff;
  logic                      ge;
  logic                      pos_sat;
  logic [PB-1:0]             pos_inc;
  logic [PB-1:0]             inc;
  logic                      hit;
  kind_t                     kind;

  // base clipped to the phase range
  assign base_wide = {{PB{1'b0}}, base_increment};
  assign base_sat  = ((base_wide >> PB) != '0) ? '1 : base_wide[PB-1:0];

  always_comb begin
    if (!fm_enable || fm == '0) begin
      kind = K_BYPASS;
    end else if (fm[FM_W-1]) begin
      kind = K_NEG;
    end else begin
      kind = K_POS;
    end
  end
  assign status.kind = kind;

  assign mag       = fm[FM_W-1] ? (MAG_W'(1) << FM_W) - {1'b0, fm} : {1'b0, fm};
  assign prod_full = {{GAIN_W{1'b0}}, mag} * {{MAG_W{1'b0}}, fm_gain};
  assign factor    = ONE_Q + {{(DIV_W-PROD_W){1'b0}}, prod};
  assign dividend  = {base_sat, {Q_SHIFT{1'b0}}};

  // one quotient bit per step
  assign trial = {rem, quo[PB-1]};
  assign diff  = trial - {1'b0, divisor};
  assign ge    = (trial >= {1'b0, divisor});

  assign pos_sat = ((product >> (PB + Q_SHIFT)) != '0);
  assign pos_inc = pos_sat ? '1 : product[PB+Q_SHIFT-1:Q_SHIFT];

  always_comb begin
    case (kind)
      K_BYPASS: inc = base_sat;
      K_POS:    inc = pos_inc;
      K_NEG:    inc = quo;
      default:  inc = base_sat;
    endcase
  end
  assign hit = (phase < inc);

  always_ff @(posedge clk) begin
    if (rst) begin
      base_increment <= BASE_RESET;
      fm_gain        <= GAIN_RESET;
      fm_enable      <= ENABLE_RESET;
      phase          <= '0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_BASE_INC:  base_increment <= wr_data;
          REG_FM_GAIN:   fm_gain        <= wr_data[GAIN_W-1:0];
          REG_FM_ENABLE: fm_enable      <= wr_data[0];
          default: begin
          end
        endcase
      end
      if (cmd.fin) begin
        phase <= phase + inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      fm <= fm_sample;
    end
    if (cmd.mag) begin
      prod <= prod_full[PROD_W-1:0];
    end
    if (cmd.mul) begin
      product <= {{DIV_W{1'b0}}, base_sat} * {{PB{1'b0}}, factor};
      divisor <= factor;
      rem     <= {{(DIV_W-Q_SHIFT){1'b0}}, dividend[PB+Q_SHIFT-1:PB]};
      quo     <= dividend[PB-1:0];
    end else if (cmd.div_step) begin
      rem <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      quo <= {quo[PB-2:0], ge};
    end
    if (cmd.fin) begin
      sample_out <= hit ? IMPULSE_LEVEL : '0;
      impulse    <= hit;
    end
  end

endmodule
